// ===== src/ews_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the event wake scheduler.
// No dependencies; every other file of the block but ews_ram refers to it by scoped names.
package ews_pkg;

    localparam int CMD_W  = 3;
    localparam int MASK_W = 16;
    localparam int CTX_W  = 32;
    localparam int SLOT_W = 4;
    localparam int CNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_SPAWN   = 3'd0,
        CMD_URGENT  = 3'd1,
        CMD_YIELD   = 3'd2,
        CMD_TERM    = 3'd3,
        CMD_TRIGGER = 3'd4,
        CMD_TICK    = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_FREE = 2'd0,
        ST_RUN  = 2'd1,
        ST_WAIT = 2'd2
    } t_slot_st;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_EV,
        S_RD,
        S_OUT
    } t_ctl_state;

    typedef logic [MASK_W-1:0] t_wmask;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic scan_rd;
        logic scan_ev;
        logic rd_cur;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== src/ews_cmd_if.sv =====
`timescale 1ns / 1ps
// Command channel: valid/ready handshake carrying one scheduler command word.
// Depends on ews_pkg for field widths.
interface ews_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [ews_pkg::CMD_W-1:0]  cmd;
    logic [ews_pkg::MASK_W-1:0] trigger_mask;
    logic [ews_pkg::CTX_W-1:0]  context_req;

    modport source (output valid, output cmd, output trigger_mask, output context_req,
                    input ready);
    modport sink   (input valid, input cmd, input trigger_mask, input context_req,
                    output ready);
endinterface

// ===== src/ews_res_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one scheduler result word.
// Depends on ews_pkg for field widths.
interface ews_res_if;
    logic                       valid;
    logic                       ready;
    logic                       status;
    logic [ews_pkg::SLOT_W-1:0] new_slot;
    logic [ews_pkg::SLOT_W-1:0] running_slot;
    logic [ews_pkg::MASK_W-1:0] wake_mask;
    logic [ews_pkg::CNT_W-1:0]  woken_count;

    modport source (output valid, output status, output new_slot, output running_slot,
                    output wake_mask, output woken_count, input ready);
    modport sink   (input valid, input status, input new_slot, input running_slot,
                    input wake_mask, input woken_count, output ready);
endinterface

// ===== src/ews_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ews_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ews_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the scheduler: takes a command word, steps the datapath through
// execute or slot scan, the mask read and the result load. Depends on ews_pkg.
module ews_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ews_pkg::t_cmd    i_in_cmd,
    output logic             o_in_ready,
    input  ews_pkg::t_dp_sts i_sts,
    output ews_pkg::t_dp_cmd o_cmd
);

    ews_pkg::t_ctl_state r_state;
    ews_pkg::t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ews_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ews_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_cmd == ews_pkg::CMD_TRIGGER || i_in_cmd == ews_pkg::CMD_TICK) begin
                        n_state = ews_pkg::S_SCAN_RD;
                    end else begin
                        n_state = ews_pkg::S_EXEC;
                    end
                end
            end
            ews_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ews_pkg::S_RD;
            end
            ews_pkg::S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = ews_pkg::S_SCAN_EV;
            end
            ews_pkg::S_SCAN_EV: begin
                o_cmd.scan_ev = 1'b1;
                n_state       = i_sts.scan_last ? ews_pkg::S_RD : ews_pkg::S_SCAN_RD;
            end
            ews_pkg::S_RD: begin
                o_cmd.rd_cur = 1'b1;
                n_state      = ews_pkg::S_OUT;
            end
            ews_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ews_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ews_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/ews_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the scheduler: slot state flops, mask/context RAM, priority
// encoders, scan counter and the result register. Depends on ews_pkg, ews_ram.
module ews_dp #(
    parameter int SLOTS        = 16,
    parameter int TRIGGER_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ews_pkg::t_cmd              i_code,
    input  logic [ews_pkg::MASK_W-1:0] i_tmask,
    input  logic [ews_pkg::CTX_W-1:0]  i_ctx,
    input  ews_pkg::t_dp_cmd           i_cmd,
    output ews_pkg::t_dp_sts           o_sts,
    ews_res_if.source                  o_res
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MW = (TRIGGER_BITS < ews_pkg::MASK_W) ? TRIGGER_BITS : ews_pkg::MASK_W;
    localparam int RW = MW + ews_pkg::CTX_W;

    ews_pkg::t_slot_st r_status [SLOTS];
    ews_pkg::t_slot_st n_status [SLOTS];
    logic [SLOTS-1:0]  r_mvld, n_mvld;
    logic [SW-1:0]     r_cur, n_cur;
    logic [SW-1:0]     r_idx, n_idx;
    logic [SW-1:0]     r_new, n_new;
    logic [CW-1:0]     r_woken, n_woken;
    logic              r_err, n_err;
    ews_pkg::t_cmd     r_cmd, n_cmd;
    logic [MW-1:0]     r_tmask, n_tmask;
    logic [ews_pkg::CTX_W-1:0] r_ctx, n_ctx;

    logic                r_o_valid, n_o_valid;
    logic                r_o_status, n_o_status;
    ews_pkg::t_slot      r_o_new, n_o_new;
    ews_pkg::t_slot      r_o_run, n_o_run;
    ews_pkg::t_wmask     r_o_wmask, n_o_wmask;
    ews_pkg::t_cnt       r_o_woken, n_o_woken;

    logic          ram_we;
    logic [SW-1:0] ram_waddr, ram_raddr;
    logic [RW-1:0] ram_wdata, ram_rdata;

    logic          free_found;
    logic [SW-1:0] free_idx, run_idx;
    logic [MW-1:0] rd_mask;
    logic [ews_pkg::CTX_W-1:0] rd_ctx;
    logic          hit;

    // Each entry is {wait mask, wait context}; a mask whose valid bit is clear reads as zero.
    ews_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Lowest free slot, and lowest running slot other than the current one.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        run_idx    = '0;
        for (int n = SLOTS - 1; n >= 0; n--) begin
            if (r_status[n] == ews_pkg::ST_FREE) begin
                free_found = 1'b1;
                free_idx   = SW'(n);
            end
            if (r_status[n] == ews_pkg::ST_RUN && SW'(n) != r_cur) begin
                run_idx = SW'(n);
            end
        end
    end

    assign rd_mask = r_mvld[r_idx] ? ram_rdata[ews_pkg::CTX_W +: MW] : '0;
    assign rd_ctx  = ram_rdata[ews_pkg::CTX_W-1:0];

    always_comb begin
        hit = 1'b0;
        if (r_status[r_idx] == ews_pkg::ST_WAIT) begin
            if (r_cmd == ews_pkg::CMD_TRIGGER) begin
                hit = ((rd_mask & r_tmask) != '0) && (rd_ctx == r_ctx || rd_ctx == '0);
            end else begin
                hit = (rd_mask == '0);
            end
        end
    end

    assign o_sts.scan_last = (r_idx == SW'(SLOTS - 1));
    assign o_sts.out_free  = !r_o_valid || o_res.ready;

    always_comb begin
        n_status   = r_status;
        n_mvld     = r_mvld;
        n_cur      = r_cur;
        n_idx      = r_idx;
        n_new      = r_new;
        n_woken    = r_woken;
        n_err      = r_err;
        n_cmd      = r_cmd;
        n_tmask    = r_tmask;
        n_ctx      = r_ctx;
        n_o_valid  = r_o_valid && !o_res.ready;
        n_o_status = r_o_status;
        n_o_new    = r_o_new;
        n_o_run    = r_o_run;
        n_o_wmask  = r_o_wmask;
        n_o_woken  = r_o_woken;
        ram_we     = 1'b0;
        ram_waddr  = r_cur;
        ram_wdata  = {r_tmask, r_ctx};
        ram_raddr  = r_cur;

        if (i_cmd.load) begin
            n_cmd   = i_code;
            n_tmask = i_tmask[MW-1:0];
            n_ctx   = i_ctx;
            n_idx   = '0;
            n_new   = '0;
            n_woken = '0;
            n_err   = 1'b0;
        end

        if (i_cmd.exec) begin
            case (r_cmd) inside
                ews_pkg::CMD_SPAWN, ews_pkg::CMD_URGENT: begin
                    if (free_found) begin
                        n_status[free_idx] = ews_pkg::ST_RUN;
                        n_mvld[free_idx]   = 1'b0;
                        n_new              = free_idx;
                        if (r_cmd == ews_pkg::CMD_URGENT) begin
                            n_cur = free_idx;
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                end
                ews_pkg::CMD_YIELD: begin
                    n_status[r_cur] = ews_pkg::ST_WAIT;
                    n_mvld[r_cur]   = 1'b1;
                    ram_we          = 1'b1;
                    n_cur           = run_idx;
                end
                ews_pkg::CMD_TERM: begin
                    n_status[r_cur] = ews_pkg::ST_FREE;
                    n_cur           = run_idx;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.scan_rd) begin
            ram_raddr = r_idx;
        end

        if (i_cmd.scan_ev) begin
            if (hit) begin
                n_status[r_idx] = ews_pkg::ST_RUN;
                n_woken         = r_woken + CW'(1);
                // A trigger leaves the raised event bits behind as the slot's mask.
                if (r_cmd == ews_pkg::CMD_TRIGGER) begin
                    n_mvld[r_idx] = 1'b1;
                    ram_we        = 1'b1;
                    ram_waddr     = r_idx;
                    ram_wdata     = {r_tmask, rd_ctx};
                end
            end
            n_idx = SW'(r_idx + SW'(1));
        end

        if (i_cmd.out_load) begin
            n_o_valid  = 1'b1;
            n_o_status = r_err;
            n_o_new    = ews_pkg::t_slot'(r_new);
            n_o_run    = ews_pkg::t_slot'(r_cur);
            n_o_wmask  = ews_pkg::t_wmask'(r_mvld[r_cur] ? ram_rdata[ews_pkg::CTX_W +: MW]
                                                           : {MW{1'b0}});
            n_o_woken  = ews_pkg::t_cnt'(r_woken);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < SLOTS; n++) begin
                r_status[n] <= (n == SLOTS - 1) ? ews_pkg::ST_RUN : ews_pkg::ST_FREE;
            end
            r_mvld    <= '0;
            r_cur     <= SW'(SLOTS - 1);
            r_o_valid <= 1'b0;
        end else begin
            r_status  <= n_status;
            r_mvld    <= n_mvld;
            r_cur     <= n_cur;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_new      <= n_new;
        r_woken    <= n_woken;
        r_err      <= n_err;
        r_cmd      <= n_cmd;
        r_tmask    <= n_tmask;
        r_ctx      <= n_ctx;
        r_o_status <= n_o_status;
        r_o_new    <= n_o_new;
        r_o_run    <= n_o_run;
        r_o_wmask  <= n_o_wmask;
        r_o_woken  <= n_o_woken;
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.status       = r_o_status;
    assign o_res.new_slot     = r_o_new;
    assign o_res.running_slot = r_o_run;
    assign o_res.wake_mask    = r_o_wmask;
    assign o_res.woken_count  = r_o_woken;

endmodule

// ===== src/event_wake_task_scheduler_top.sv =====
`timescale 1ns / 1ps
// Event wake task scheduler: a table of SLOTS task slots, each free, running or waiting,
// driven by spawn, urgent spawn, yield, terminate, trigger and tick command words, with one
// result word per command. Spawn, yield, terminate and unknown commands step through accept,
// execute, a read of the current slot's mask from the slot RAM and the result load; trigger
// and tick replace the execute step with a scan over the slot RAM, which has one read port,
// and so reads and then evaluates every slot in turn. A finished result waits in the output
// register while the next word is accepted. Wait masks reset to zero through per-slot valid
// bits, so no clearing pass is needed after reset.
// Depends on ews_pkg, ews_cmd_if, ews_res_if, ews_ctrl and ews_dp.
module event_wake_task_scheduler_top #(
    parameter int SLOTS        = 16,
    parameter int TRIGGER_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ews_cmd_if.sink   i_cmd,
    ews_res_if.source o_res
);

    ews_pkg::t_dp_cmd w_dp_cmd;
    ews_pkg::t_dp_sts w_dp_sts;
    logic             w_in_ready;
    ews_pkg::t_cmd    w_code;

    assign w_code      = ews_pkg::t_cmd'(i_cmd.cmd);
    assign i_cmd.ready = w_in_ready;

    ews_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_in_cmd   (w_code),
        .o_in_ready (w_in_ready),
        .i_sts      (w_dp_sts),
        .o_cmd      (w_dp_cmd)
    );

    ews_dp #(
        .SLOTS        (SLOTS),
        .TRIGGER_BITS (TRIGGER_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_code  (w_code),
        .i_tmask (i_cmd.trigger_mask),
        .i_ctx   (i_cmd.context_req),
        .i_cmd   (w_dp_cmd),
        .o_sts   (w_dp_sts),
        .o_res   (o_res)
    );

    // A word in progress blocks the command channel until its result is loaded.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("command accepted while the previous word was in progress");

    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_dp_cmd.load, w_dp_cmd.exec, w_dp_cmd.scan_rd, w_dp_cmd.scan_ev,
                  w_dp_cmd.rd_cur, w_dp_cmd.out_load}))
        else $error("more than one datapath phase active");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dp_cmd.out_load |-> (!o_res.valid || o_res.ready))
        else $error("result register loaded over an untaken result");

    a_wake_not_spawn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.woken_count != '0) |-> (!o_res.status && o_res.new_slot == '0))
        else $error("woken slots reported together with a spawn result");

endmodule
